/* rtl/unba_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Unit number bitmap allocator package
// Shared codes, widths and defaults for the unit number bitmap allocator.
// ============================================================================
package unba_pkg;

    localparam int UNIT_W     = 15;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int DEF_UNIT_LIMIT = 32768;
    localparam int DEF_WORD_BITS  = 64;

    localparam int SCAN_BITS = 64;
    localparam int SCAN_LOG  = 6;

    localparam logic [UNIT_W-1:0] HIGHEST_RESET = 15'h7fff;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EXISTS  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFUSE_ALLOC = 2'd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_MUL,
        S_DIV_FIX,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_FIND,
        S_LOCATE,
        S_RESULT
    } unba_state_t;

endpackage

/* rtl/unit_number_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ============================================================================
// Unit number bitmap allocator
// Allocates and frees unit numbers held in a bitmap memory, with a summary
// of full words for the lowest free unit search.
// ============================================================================
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-------------------------------------------
//  input    | s_valid / s_ready   | s_operation, s_want_any, s_unit_number
//  result   | m_valid / m_ready   | m_status, m_granted_unit
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset a clearing pass zeroes the bitmap memory, one word a cycle; no input is
// taken then. A free or a specific allocate passes S_DIV_MUL, S_DIV_FIX, S_READ and
// S_MODIFY before it offers its result; a refused allocate, an out-of-range specific
// allocate or an out-of-range free offers its result straight from acceptance.
// An allocate of any unit passes S_DIV_MUL, S_DIV_FIX, S_SCAN, S_READ, S_FIND and S_LOCATE,
// scanning 1 to ceil(words / 64) summary chunks, one a cycle; no free word ends it in S_SCAN.
// One transaction is in progress at a time; the result is held until taken, and the
// input is ready again on the cycle after the result is taken.

module unit_number_bitmap_allocator #(
    parameter int UNIT_LIMIT = unba_pkg::DEF_UNIT_LIMIT,
    parameter int WORD_BITS  = unba_pkg::DEF_WORD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic                             s_want_any,
    input  logic [unba_pkg::UNIT_W-1:0]      s_unit_number,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [unba_pkg::STATUS_W-1:0]    m_status,
    output logic [unba_pkg::UNIT_W-1:0]      m_granted_unit,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [unba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [unba_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import unba_pkg::*;

    localparam int WORD_COUNT = (UNIT_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CHUNKS     = (WORD_COUNT + SCAN_BITS - 1) / SCAN_BITS;
    localparam int CIDX_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int FLAG_N     = CHUNKS * SCAN_BITS;
    localparam int FIDX_W     = $clog2(FLAG_N);
    localparam int DIV_K      = 16;
    localparam int PROD_W     = 32;
    localparam int RECIP_I    = (1 << DIV_K) / WORD_BITS;
    localparam int MW         = UNIT_W + BIT_W + 1;
    localparam int UC_W       = WIDX_W + BIT_W + 1;
    localparam int CMP_W      = 24;

    localparam logic [PROD_W-1:0] RECIP      = PROD_W'(RECIP_I);
    localparam logic [MW-1:0]     WB_M       = MW'(WORD_BITS);
    localparam logic [UC_W-1:0]   WB_U       = UC_W'(WORD_BITS);
    localparam logic [16:0]       LIMIT_TOP  = 17'(UNIT_LIMIT - 1);
    localparam logic [FLAG_N-1:0] PAD_FULL   = {FLAG_N{1'b1}} << WORD_COUNT;
    localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(WORD_COUNT - 1);
    localparam logic [CIDX_W-1:0] LAST_CHUNK = CIDX_W'(CHUNKS - 1);

    unba_state_t state_reg, state_next;

    logic [UNIT_W-1:0]    highest_reg, highest_next;
    logic                 refuse_reg, refuse_next;
    logic [FLAG_N-1:0]    full_reg, full_next;
    logic [WIDX_W-1:0]    clr_reg, clr_next;
    logic [CIDX_W-1:0]    chunk_reg, chunk_next;

    logic                 op_reg, op_next;
    logic                 any_reg, any_next;
    logic [UNIT_W-1:0]    unit_reg, unit_next;
    logic [UNIT_W-1:0]    q_reg, q_next;
    logic [UNIT_W-1:0]    topw_reg, topw_next;
    logic [WIDX_W-1:0]    word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [UNIT_W-1:0]    granted_reg, granted_next;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [UNIT_W-1:0]    top;
    logic [UNIT_W-1:0]    div_opd;
    logic [PROD_W-1:0]    prod;
    logic [MW-1:0]        qw_prod;
    logic [MW-1:0]        rem_raw;
    logic [UC_W-1:0]      unit_calc;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] word_set;
    logic [SCAN_BITS-1:0] chunk_flags;
    logic                 chunk_has_free;
    logic [SCAN_LOG-1:0]  chunk_pos;
    logic [FIDX_W-1:0]    scan_word;
    logic [BIT_W-1:0]     free_pos;

    assign top = ({2'b00, highest_reg} > LIMIT_TOP) ? LIMIT_TOP[UNIT_W-1:0] : highest_reg;
    assign div_opd = (op_reg == OP_ALLOC && any_reg) ? top : unit_reg;

    assign prod      = PROD_W'(div_opd) * RECIP;
    assign qw_prod   = MW'(q_reg) * WB_M;
    assign rem_raw   = MW'(div_opd) - qw_prod;
    assign unit_calc = UC_W'(word_reg) * WB_U + UC_W'(bit_reg);
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign word_set  = rd_word_reg | bit_mask;

    assign chunk_flags = full_reg[chunk_reg * SCAN_BITS +: SCAN_BITS];
    assign scan_word   = (FIDX_W'(chunk_reg) << SCAN_LOG) + FIDX_W'(chunk_pos);

    always_comb begin
        chunk_has_free = 1'b0;
        chunk_pos      = '0;
        for (int i = SCAN_BITS - 1; i >= 0; i--) begin
            if (!chunk_flags[i]) begin
                chunk_has_free = 1'b1;
                chunk_pos      = SCAN_LOG'(i);
            end
        end
    end

    always_comb begin
        free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_word_reg[i]) begin
                free_pos = BIT_W'(i);
            end
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_RESULT);
    assign m_status       = status_reg;
    assign m_granted_unit = granted_reg;
    assign cfg_ready      = 1'b1;

    always_comb begin
        highest_next = highest_reg;
        refuse_next  = refuse_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_HIGHEST_UNIT: highest_next = cfg_data;
                REG_REFUSE_ALLOC: refuse_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        full_next    = full_reg;
        clr_next     = clr_reg;
        chunk_next   = chunk_reg;
        op_next      = op_reg;
        any_next     = any_reg;
        unit_next    = unit_reg;
        q_next       = q_reg;
        topw_next    = topw_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        mem_we       = 1'b0;
        mem_addr     = word_reg;
        mem_wdata    = word_set;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + WIDX_W'(1);
                if (clr_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    any_next     = s_want_any;
                    unit_next    = s_unit_number;
                    status_next  = STAT_OK;
                    granted_next = '0;
                    chunk_next   = '0;
                    if (s_operation == OP_FREE) begin
                        state_next = (s_unit_number > top) ? S_RESULT : S_DIV_MUL;
                    end else if (refuse_reg) begin
                        status_next = STAT_REFUSED;
                        state_next  = S_RESULT;
                    end else if (!s_want_any && s_unit_number > top) begin
                        status_next = STAT_NOSPACE;
                        state_next  = S_RESULT;
                    end else begin
                        state_next = S_DIV_MUL;
                    end
                end
            end
            S_DIV_MUL: begin
                q_next     = UNIT_W'(prod >> DIV_K);
                state_next = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                if (rem_raw >= WB_M) begin
                    q_next   = q_reg + UNIT_W'(1);
                    bit_next = BIT_W'(rem_raw - WB_M);
                end else begin
                    bit_next = BIT_W'(rem_raw);
                end
                if (op_reg == OP_ALLOC && any_reg) begin
                    topw_next  = (rem_raw >= WB_M) ? q_reg + UNIT_W'(1) : q_reg;
                    state_next = S_SCAN;
                end else begin
                    word_next  = (rem_raw >= WB_M) ? WIDX_W'(q_reg + UNIT_W'(1))
                                                   : WIDX_W'(q_reg);
                    state_next = S_READ;
                end
            end
            S_SCAN: begin
                if (chunk_has_free) begin
                    if (CMP_W'(scan_word) > CMP_W'(topw_reg)) begin
                        status_next = STAT_NOSPACE;
                        state_next  = S_RESULT;
                    end else begin
                        word_next  = WIDX_W'(scan_word);
                        state_next = S_READ;
                    end
                end else if (chunk_reg == LAST_CHUNK) begin
                    status_next = STAT_NOSPACE;
                    state_next  = S_RESULT;
                end else begin
                    chunk_next = chunk_reg + CIDX_W'(1);
                end
            end
            S_READ: begin
                state_next = (op_reg == OP_ALLOC && any_reg) ? S_FIND : S_MODIFY;
            end
            S_MODIFY: begin
                state_next = S_RESULT;
                if (op_reg == OP_FREE) begin
                    mem_we                        = 1'b1;
                    mem_wdata                     = rd_word_reg & ~bit_mask;
                    full_next[FIDX_W'(word_reg)]  = 1'b0;
                end else if (rd_word_reg[bit_reg]) begin
                    status_next = STAT_EXISTS;
                end else begin
                    mem_we                        = 1'b1;
                    full_next[FIDX_W'(word_reg)]  = &word_set;
                    granted_next                  = unit_reg;
                end
            end
            S_FIND: begin
                bit_next   = free_pos;
                state_next = S_LOCATE;
            end
            S_LOCATE: begin
                state_next = S_RESULT;
                if (CMP_W'(unit_calc) > CMP_W'(top)) begin
                    status_next = STAT_NOSPACE;
                end else begin
                    mem_we                        = 1'b1;
                    full_next[FIDX_W'(word_reg)]  = &word_set;
                    granted_next                  = UNIT_W'(unit_calc);
                end
            end
            S_RESULT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            highest_reg <= HIGHEST_RESET;
            refuse_reg  <= 1'b0;
            full_reg    <= PAD_FULL;
            clr_reg     <= '0;
            chunk_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            highest_reg <= highest_next;
            refuse_reg  <= refuse_next;
            full_reg    <= full_next;
            clr_reg     <= clr_next;
            chunk_reg   <= chunk_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        any_reg     <= any_next;
        unit_reg    <= unit_next;
        q_reg       <= q_next;
        topw_reg    <= topw_next;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_word_reg <= mem[mem_addr];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Ready did not drop after an accepted transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_granted_unit == '0)
        else $error("Non-zero unit granted with a failing status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_REFUSED |-> refuse_reg)
        else $error("Refusal reported while allocation is enabled");

endmodule
